// ----- rtl/fqks_pkg.sv -----
// Shared widths, codes and record types of the record queue with key search.
// Used by fqks_front, fqks_back and fifo_queue_with_key_search_core; depends on nothing.
package fqks_pkg;

	localparam int FUNC_W    = 2;
	localparam int KEY_W     = 64;
	localparam int PROG_W    = 64;
	localparam int CRS_W     = 8;
	localparam int AVG_W     = 14;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 6;
	localparam int OCC_W     = 7;
	localparam int DEPTH_DEF = 64;

	// operation codes on the func field
	localparam logic [FUNC_W-1:0] FN_ENQ  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SRCH = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PROG_W-1:0] prog;
		logic [CRS_W-1:0]  courses;
		logic [AVG_W-1:0]  avg;
	} record_t;

	// command class flags; none set means no operation
	typedef struct packed {
		logic enq;
		logic deq;
		logic srch;
	} op_class_t;

	typedef struct packed {
		op_class_t op;
		record_t   rec;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  position;
		record_t           rec;
		logic [OCC_W-1:0]  occupancy;
	} res_t;

endpackage

// ----- rtl/fqks_fifo.sv -----
// Two-entry first-in first-out buffer of W-bit words with push/full and pop/empty.
// Stands between the front and the back and ahead of the result ports; no package needed.
module fqks_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push_ok;
	logic         pop_ok;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
		end
	end

endmodule

// ----- rtl/fqks_front.sv -----
// Front end: accepts input transactions, sorts them into operation classes
// and queues them for the back end. Depends on fqks_pkg and fqks_fifo.
module fqks_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [fqks_pkg::FUNC_W-1:0] func,
	input  fqks_pkg::record_t           rec,
	output logic                        cmd_valid,
	output fqks_pkg::cmd_t              cmd,
	input  logic                        cmd_pop
);
	import fqks_pkg::*;

	cmd_t cmd_in;
	logic cmd_empty;

	// decode the operation once here; code 3 leaves all flags low
	always_comb begin
		cmd_in.op.enq  = (func == FN_ENQ);
		cmd_in.op.deq  = (func == FN_DEQ);
		cmd_in.op.srch = (func == FN_SRCH);
		cmd_in.rec     = rec;
	end

	fqks_fifo #(.W($bits(cmd_t))) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

// ----- rtl/fqks_back.sv -----
// Back end: record memory, head pointer and count, and the sequencer that
// carries out enqueue, dequeue and key search. Depends on fqks_pkg.
module fqks_back #(
	parameter int DEPTH = fqks_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  fqks_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              res_push,
	output fqks_pkg::res_t    res,
	input  logic              res_full
);
	import fqks_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEQ  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	record_t mem [DEPTH];
	record_t rd_q;

	logic [1:0]        state_q;
	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  scan_slot_q;
	logic [PTR_W-1:0]  cmp_idx_q;
	logic [KEY_W-1:0]  key_q;
	logic [STAT_W-1:0] status_q;
	logic [POS_W-1:0]  pos_q;
	record_t           orec_q;

	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic              wr_en;
	logic [SUM_W-1:0]  tail_sum;
	logic [PTR_W-1:0]  tail;
	logic              is_full;
	logic              is_empty;
	logic              match;
	logic              last;

	function automatic logic [PTR_W-1:0] inc_slot(input logic [PTR_W-1:0] p);
		inc_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign tail_sum = SUM_W'(head_q) + SUM_W'(cnt_q);
	assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
	                                              : PTR_W'(tail_sum);
	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);
	assign match    = (rd_q.key == key_q);
	assign last     = ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == cnt_q);

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign res_push = (state_q == S_EMIT) && !res_full;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		if (cmd_pop) begin
			wr_en = cmd.op.enq && !is_full;
			rd_en = (cmd.op.deq || cmd.op.srch) && !is_empty;
		end
		if (state_q == S_SCAN) begin
			rd_en   = 1'b1;
			rd_addr = scan_slot_q;
		end
	end

	always_comb begin
		res.status    = status_q;
		res.position  = pos_q;
		res.rec       = orec_q;
		res.occupancy = OCC_W'(cnt_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail] <= cmd.rec;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					key_q       <= cmd.rec.key;
					pos_q       <= '0;
					orec_q      <= '0;
					scan_slot_q <= inc_slot(head_q);
					cmp_idx_q   <= '0;
					if (cmd.op.enq && is_full) begin
						status_q <= ST_FULL;
					end else if (cmd.op.deq && is_empty) begin
						status_q <= ST_EMPTY;
					end else if (cmd.op.srch && is_empty) begin
						status_q <= ST_NOTFOUND;
					end else begin
						status_q <= ST_OK;
					end
				end
			end
			S_DEQ: begin
				orec_q <= rd_q;
			end
			S_SCAN: begin
				if (match) begin
					pos_q <= POS_W'(cmp_idx_q);
				end else if (last) begin
					status_q <= ST_NOTFOUND;
				end else begin
					cmp_idx_q   <= cmp_idx_q + PTR_W'(1);
					scan_slot_q <= inc_slot(scan_slot_q);
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						if (wr_en) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (cmd.op.deq && !is_empty) begin
							state_q <= S_DEQ;
						end else if (cmd.op.srch && !is_empty) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_DEQ: begin
					head_q  <= inc_slot(head_q);
					cnt_q   <= cnt_q - CNT_W'(1);
					state_q <= S_EMIT;
				end
				S_SCAN: begin
					if (match || last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_push) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("record count above depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (!is_empty && (CNT_W'(cmp_idx_q) < cnt_q)))
		else $error("search index outside held records");

	a_cmd_gets_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q != S_IDLE))
		else $error("command taken without a pending result");

	a_push_frees: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (state_q == S_IDLE))
		else $error("sequencer busy after result push");

endmodule

// ----- rtl/fifo_queue_with_key_search_core.sv -----
// Top level of the record queue with linear key search.
// Depends on fqks_pkg, fqks_front, fqks_back and fqks_fifo.

// A bounded first-in first-out store of DEPTH records (key, program code,
// courses passed, grade average in hundredths). Each input transaction on
// push/full carries one operation in func: 0 enqueue, 1 dequeue the oldest
// record, 2 search for the first record whose key equals name_key; code 3
// does nothing. Every operation yields exactly one result transaction on
// empty/pop, in order, with a status (ok, full, empty, not found), the
// search position (records ahead of the match), the dequeued record (zero
// otherwise) and the occupancy after the operation. A two-entry command
// queue in front and a two-entry result queue behind let both sides stall
// freely; operations are carried out one at a time by the back end. Steps per
// operation in the back end: enqueue, no-op and every refused operation go
// from idle straight to the emit state; a dequeue first passes a read state
// (one registered memory read), and a search compares the stored keys, one
// per cycle from the oldest record, until a match or the last record. A
// result waits in the emit state while the result queue is full. Records are
// not cleared at reset; the head pointer, count and sequencer state are.
module fifo_queue_with_key_search_core #(
	parameter int DEPTH = fqks_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input queue side
	input  logic                         push,
	output logic                         full,
	input  logic [fqks_pkg::FUNC_W-1:0]  func,
	input  logic [fqks_pkg::KEY_W-1:0]   name_key,
	input  logic [fqks_pkg::PROG_W-1:0]  program_code,
	input  logic [fqks_pkg::CRS_W-1:0]   courses_passed,
	input  logic [fqks_pkg::AVG_W-1:0]   grade_average,
	// result queue side
	output logic                         empty,
	input  logic                         pop,
	output logic [fqks_pkg::STAT_W-1:0]  status,
	output logic [fqks_pkg::POS_W-1:0]   position,
	output logic [fqks_pkg::KEY_W-1:0]   out_name_key,
	output logic [fqks_pkg::PROG_W-1:0]  out_program_code,
	output logic [fqks_pkg::CRS_W-1:0]   out_courses_passed,
	output logic [fqks_pkg::AVG_W-1:0]   out_grade_average,
	output logic [fqks_pkg::OCC_W-1:0]   occupancy
);
	import fqks_pkg::*;

	record_t in_rec;
	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_pop;
	res_t    res_in;
	res_t    res_out;
	logic    res_push;
	logic    res_full;

	// pack the input fields into one record
	always_comb begin
		in_rec.key     = name_key;
		in_rec.prog    = program_code;
		in_rec.courses = courses_passed;
		in_rec.avg     = grade_average;
	end

	// front: accept and classify transactions, hold them for the back end
	fqks_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.rec      (in_rec),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// back: memory and sequencer; advance one command at a time
	fqks_back #(.DEPTH(DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res_in),
		.res_full (res_full)
	);

	// result queue: hold finished results until the consumer pops them
	fqks_fifo #(.W($bits(res_t))) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	// unpack the oldest result onto the ports
	assign status             = res_out.status;
	assign position           = res_out.position;
	assign out_name_key       = res_out.rec.key;
	assign out_program_code   = res_out.rec.prog;
	assign out_courses_passed = res_out.rec.courses;
	assign out_grade_average  = res_out.rec.avg;
	assign occupancy          = res_out.occupancy;

endmodule
